[design/s5h_pkg.sv]
// Shared types, codes and constants for the SOCKS5 server handshake block.
`timescale 1ns / 1ps
package s5h_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 12;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // result kinds
    localparam logic [2:0] K_REPLY   = 3'd0;
    localparam logic [2:0] K_ADDR    = 3'd1;
    localparam logic [2:0] K_SUMMARY = 3'd2;
    localparam logic [2:0] K_STATUS  = 3'd3;
    localparam logic [2:0] K_PAYLOAD = 3'd4;

    // status codes
    localparam logic [3:0] ST_DONE         = 4'd0;
    localparam logic [3:0] ST_BAD_VERSION  = 4'd1;
    localparam logic [3:0] ST_NO_METHODS   = 4'd2;
    localparam logic [3:0] ST_NO_ACCEPT    = 4'd3;
    localparam logic [3:0] ST_UNKNOWN_CMD  = 4'd4;
    localparam logic [3:0] ST_UNSUPPORTED  = 4'd5;
    localparam logic [3:0] ST_ZERO_DOMAIN  = 4'd6;
    localparam logic [3:0] ST_UNKNOWN_ATYP = 4'd7;
    localparam logic [3:0] ST_PEER_CLOSED  = 4'd8;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER       = 8'h05;
    localparam logic [7:0] METHOD_NO_AUTH  = 8'h00;
    localparam logic [7:0] METHOD_NONE     = 8'hFF;
    localparam logic [7:0] REP_OK          = 8'h00;
    localparam logic [7:0] REP_UNSUPPORTED = 8'h07;
    localparam logic [7:0] RSV_BYTE        = 8'h00;
    localparam logic [7:0] CMD_CONNECT     = 8'h01;
    localparam logic [7:0] CMD_BIND        = 8'h02;
    localparam logic [7:0] CMD_UDP         = 8'h03;
    localparam logic [7:0] ATYP_IPV4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
    localparam logic [7:0] ATYP_IPV6       = 8'h04;

    // destination kinds in the summary
    localparam logic [1:0] DK_IPV4   = 2'd0;
    localparam logic [1:0] DK_DOMAIN = 2'd1;
    localparam logic [1:0] DK_IPV6   = 2'd2;

    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       peer_closed;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [1:0]  addr_kind;
        logic [7:0]  address_length;
        logic [15:0] dest_port;
        logic [3:0]  status;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        JOB_SINGLE,
        JOB_FAIL,
        JOB_METHOD_OK,
        JOB_METHOD_BAD,
        JOB_FINISH
    } t_job_op;

    typedef struct packed {
        t_job_op     op;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [3:0]  status;
        logic [1:0]  addr_type;
        logic [7:0]  addr_len;
        logic [15:0] port;
        logic        reject;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/s5h_front.sv]
// Front end: parses client bytes and queues one job per byte that causes results.
`timescale 1ns / 1ps
module s5h_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  s5h_pkg::t_in_item i_item,
    output logic              o_push,
    output s5h_pkg::t_job     o_job
);
    import s5h_pkg::*;

    typedef enum logic [2:0] {
        PH_GREET,
        PH_METHODS,
        PH_REQ,
        PH_ADDR,
        PH_PORT,
        PH_OPEN,
        PH_CLOSED
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_count, n_count;
    logic [7:0] r_methods_left, n_methods_left;
    logic       r_none_offered, n_none_offered;
    logic [7:0] r_hdr [4];
    logic [7:0] n_hdr [4];
    logic       r_reject, n_reject;
    logic [1:0] r_dest_kind, n_dest_kind;
    logic [7:0] r_addr_left, n_addr_left;
    logic [7:0] r_addr_total, n_addr_total;
    logic [7:0] r_port_hi, n_port_hi;
    logic [7:0] b;

    assign b = i_item.rx_byte;

    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        n_methods_left = r_methods_left;
        n_none_offered = r_none_offered;
        n_hdr          = r_hdr;
        n_reject       = r_reject;
        n_dest_kind    = r_dest_kind;
        n_addr_left    = r_addr_left;
        n_addr_total   = r_addr_total;
        n_port_hi      = r_port_hi;
        o_push         = 1'b0;
        o_job          = '0;
        o_job.op       = JOB_SINGLE;

        if (i_accept && r_phase != PH_CLOSED) begin
            if (i_item.peer_closed) begin
                n_phase = PH_CLOSED;
                if (r_phase != PH_OPEN) begin
                    o_push       = 1'b1;
                    o_job.op     = JOB_FAIL;
                    o_job.status = ST_PEER_CLOSED;
                end
            end else begin
                unique case (r_phase)
                    PH_GREET: begin
                        if (r_count == 3'd0) begin
                            n_hdr[0] = b;
                            n_count  = 3'd1;
                        end else begin
                            n_count = 3'd0;
                            if (r_hdr[0] != SOCKS_VER) begin
                                n_phase      = PH_CLOSED;
                                o_push       = 1'b1;
                                o_job.op     = JOB_FAIL;
                                o_job.status = ST_BAD_VERSION;
                            end else if (b == 8'd0) begin
                                n_phase      = PH_CLOSED;
                                o_push       = 1'b1;
                                o_job.op     = JOB_FAIL;
                                o_job.status = ST_NO_METHODS;
                            end else begin
                                n_methods_left = b;
                                n_none_offered = 1'b0;
                                n_phase        = PH_METHODS;
                            end
                        end
                    end
                    PH_METHODS: begin
                        n_none_offered = r_none_offered | (b == METHOD_NO_AUTH);
                        n_methods_left = r_methods_left - 8'd1;
                        if (r_methods_left == 8'd1) begin
                            o_push = 1'b1;
                            if (n_none_offered) begin
                                o_job.op = JOB_METHOD_OK;
                                n_phase  = PH_REQ;
                                n_count  = 3'd0;
                            end else begin
                                o_job.op = JOB_METHOD_BAD;
                                n_phase  = PH_CLOSED;
                            end
                        end
                    end
                    PH_REQ: begin
                        if (!r_count[2]) begin
                            n_hdr[r_count[1:0]] = b;
                            n_count             = r_count + 3'd1;
                        end else begin
                            n_count  = 3'd0;
                            o_job.op = JOB_FAIL;
                            n_phase  = PH_CLOSED;
                            if (r_hdr[0] != SOCKS_VER || r_hdr[2] != RSV_BYTE) begin
                                o_push       = 1'b1;
                                o_job.status = ST_BAD_VERSION;
                            end else if (r_hdr[1] != CMD_CONNECT && r_hdr[1] != CMD_BIND
                                         && r_hdr[1] != CMD_UDP) begin
                                o_push       = 1'b1;
                                o_job.status = ST_UNKNOWN_CMD;
                            end else if (r_hdr[3] == ATYP_DOMAIN) begin
                                if (b == 8'd0) begin
                                    o_push       = 1'b1;
                                    o_job.status = ST_ZERO_DOMAIN;
                                end else begin
                                    n_reject     = (r_hdr[1] != CMD_CONNECT);
                                    n_dest_kind  = DK_DOMAIN;
                                    n_addr_total = b;
                                    n_addr_left  = b;
                                    n_phase      = PH_ADDR;
                                end
                            end else if (r_hdr[3] == ATYP_IPV4 || r_hdr[3] == ATYP_IPV6) begin
                                n_reject     = (r_hdr[1] != CMD_CONNECT);
                                n_dest_kind  = (r_hdr[3] == ATYP_IPV4) ? DK_IPV4 : DK_IPV6;
                                n_addr_total = (r_hdr[3] == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
                                n_addr_left  = n_addr_total - 8'd1;
                                n_phase      = PH_ADDR;
                                o_push       = 1'b1;
                                o_job.op     = JOB_SINGLE;
                                o_job.kind   = K_ADDR;
                                o_job.data   = b;
                            end else begin
                                o_push       = 1'b1;
                                o_job.status = ST_UNKNOWN_ATYP;
                            end
                        end
                    end
                    PH_ADDR: begin
                        o_push      = 1'b1;
                        o_job.kind  = K_ADDR;
                        o_job.data  = b;
                        n_addr_left = r_addr_left - 8'd1;
                        if (r_addr_left == 8'd1) begin
                            n_phase = PH_PORT;
                            n_count = 3'd0;
                        end
                    end
                    PH_PORT: begin
                        if (r_count == 3'd0) begin
                            n_port_hi = b;
                            n_count   = 3'd1;
                        end else begin
                            n_count         = 3'd0;
                            o_push          = 1'b1;
                            o_job.op        = JOB_FINISH;
                            o_job.addr_type = r_dest_kind;
                            o_job.addr_len  = r_addr_total;
                            o_job.port      = {r_port_hi, b};
                            o_job.reject    = r_reject;
                            n_phase         = r_reject ? PH_CLOSED : PH_OPEN;
                        end
                    end
                    PH_OPEN: begin
                        o_push     = 1'b1;
                        o_job.kind = K_PAYLOAD;
                        o_job.data = b;
                    end
                    default: begin
                        n_phase = PH_CLOSED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_GREET;
            r_count        <= 3'd0;
            r_methods_left <= 8'd0;
            r_none_offered <= 1'b0;
            r_reject       <= 1'b0;
            r_dest_kind    <= DK_IPV4;
            r_addr_left    <= 8'd0;
            r_addr_total   <= 8'd0;
            r_port_hi      <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_methods_left <= n_methods_left;
            r_none_offered <= n_none_offered;
            r_reject       <= n_reject;
            r_dest_kind    <= n_dest_kind;
            r_addr_left    <= n_addr_left;
            r_addr_total   <= n_addr_total;
            r_port_hi      <= n_port_hi;
        end
        r_hdr <= n_hdr;
    end

endmodule

[design/s5h_fifo.sv]
// Short job queue between the parser and the result sequencer.
`timescale 1ns / 1ps
module s5h_fifo #(
    parameter int DEPTH = s5h_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  s5h_pkg::t_job      i_data,
    input  logic               i_pop,
    output s5h_pkg::t_job      o_head,
    output s5h_pkg::t_q_status o_status
);
    import s5h_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/s5h_back.sv]
// Back end: expands each queued job into result items, one per cycle unless the output stalls.
`timescale 1ns / 1ps
module s5h_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  s5h_pkg::t_job      i_head,
    input  logic               i_empty,
    input  logic               i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output s5h_pkg::t_out_item o_item
);
    import s5h_pkg::*;

    localparam logic [IDX_W-1:0] FINISH_LAST = IDX_W'(MAX_RESULTS - 1);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_out_item        r_item;
    t_out_item        n_item;
    logic             adv;

    assign adv     = !i_empty && (!r_valid || !i_stall);
    assign o_pop   = adv && n_item.last;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item      = '0;
        n_item.kind = K_REPLY;
        unique case (i_head.op)
            JOB_SINGLE: begin
                n_item.kind = i_head.kind;
                n_item.data = i_head.data;
                n_item.last = 1'b1;
            end
            JOB_FAIL: begin
                n_item.kind   = K_STATUS;
                n_item.status = i_head.status;
                n_item.last   = 1'b1;
            end
            JOB_METHOD_OK: begin
                n_item.data = (r_idx == '0) ? SOCKS_VER : METHOD_NO_AUTH;
                n_item.last = (r_idx != '0);
            end
            JOB_METHOD_BAD: begin
                if (r_idx == IDX_W'(0)) begin
                    n_item.data = SOCKS_VER;
                end else if (r_idx == IDX_W'(1)) begin
                    n_item.data = METHOD_NONE;
                end else begin
                    n_item.kind   = K_STATUS;
                    n_item.status = ST_NO_ACCEPT;
                    n_item.last   = 1'b1;
                end
            end
            JOB_FINISH: begin
                if (r_idx == IDX_W'(0)) begin
                    n_item.kind           = K_SUMMARY;
                    n_item.addr_kind      = i_head.addr_type;
                    n_item.address_length = i_head.addr_len;
                    n_item.dest_port      = i_head.port;
                end else if (r_idx == IDX_W'(1)) begin
                    n_item.data = SOCKS_VER;
                end else if (r_idx == IDX_W'(2)) begin
                    n_item.data = i_head.reject ? REP_UNSUPPORTED : REP_OK;
                end else if (r_idx == IDX_W'(4)) begin
                    n_item.data = ATYP_IPV4;
                end else if (r_idx == FINISH_LAST) begin
                    n_item.kind   = K_STATUS;
                    n_item.status = i_head.reject ? ST_UNSUPPORTED : ST_DONE;
                    n_item.last   = 1'b1;
                end else begin
                    n_item.data = 8'h00;
                end
            end
            default: begin
                n_item.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                r_idx   <= n_item.last ? '0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (adv) begin
            r_item <= n_item;
        end
    end

endmodule

[design/socks5_server_handshake.sv]
// Top level of the SOCKS5 server handshake block.
`timescale 1ns / 1ps
// One client byte is taken per cycle while the job queue (QUEUE_DEPTH entries)
// has room; results leave through a registered output at one per cycle while
// the output is not stalled. A byte that causes several results holds the
// result sequencer until all have left: two or three for the method reply,
// twelve for the request reply, one otherwise, so a run of such bytes stalls
// input once the queue fills. The first result of a byte passes through the
// job queue and then the output register. After a failure or a peer close the
// block ignores all input until reset.
module socks5_server_handshake #(
    parameter int QUEUE_DEPTH = s5h_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  s5h_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output s5h_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import s5h_pkg::*;

    t_job      front_job;
    t_job      q_head;
    t_q_status q_status;
    logic      in_accept;
    logic      push;
    logic      pop;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    s5h_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_job    (front_job)
    );

    s5h_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_job),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    s5h_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_status.empty),
        .i_stall (i_out_stall),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == K_STATUS) |-> o_out_item.last)
        else $error("status result not marked last");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == K_SUMMARY)
            |-> (o_out_item.data == 8'h00 && o_out_item.status == ST_DONE
                 && !o_out_item.last))
        else $error("summary carries stray fields");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the SOCKS5 server handshake block.
`timescale 1ns / 1ps
module testbench;
    import s5h_pkg::*;

    typedef enum logic [2:0] {
        PH_GREETING,
        PH_METHODS,
        PH_REQUEST,
        PH_ADDRESS,
        PH_PORT,
        PH_OPEN,
        PH_CLOSED
    } t_phase;

    localparam int N_ITEMS = 420;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    socks5_server_handshake dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (out_stall)
    );

    always #6 clk = ~clk;

    // shadow of the server state
    t_phase      hs_phase = PH_GREETING;
    logic [7:0]  hs_count = '0;
    logic [7:0]  methods_left = '0;
    logic        no_auth_seen = 1'b0;
    logic [7:0]  hdr [4];
    logic [7:0]  rep_code = '0;
    logic [1:0]  dest_kind = '0;
    logic [7:0]  addr_left = '0;
    logic [7:0]  addr_total = '0;
    logic [15:0] port_value = '0;

    t_out_item server_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int error_count = 0;
    int method_count = 0;
    logic [7:0] req_atyp = '0;

    function automatic void emit(input logic [2:0] kind, input logic [7:0] data,
                                 input logic [1:0] at, input logic [7:0] alen,
                                 input logic [15:0] port, input logic [3:0] st);
        t_out_item r;
        r.kind           = kind;
        r.data           = data;
        r.addr_kind      = at;
        r.address_length = alen;
        r.dest_port      = port;
        r.status         = st;
        r.last           = 1'b0;
        server_results.push_back(r);
    endfunction

    function automatic void abort_exchange(input logic [3:0] st);
        hs_phase = PH_CLOSED;
        emit(K_STATUS, 8'h00, 2'd0, 8'd0, 16'd0, st);
    endfunction

    function automatic void send_reply();
        emit(K_SUMMARY, 8'h00, dest_kind, addr_total, port_value, ST_DONE);
        emit(K_REPLY, SOCKS_VER, 2'd0, 8'd0, 16'd0, ST_DONE);
        emit(K_REPLY, rep_code, 2'd0, 8'd0, 16'd0, ST_DONE);
        emit(K_REPLY, RSV_BYTE, 2'd0, 8'd0, 16'd0, ST_DONE);
        emit(K_REPLY, ATYP_IPV4, 2'd0, 8'd0, 16'd0, ST_DONE);
        for (int i = 0; i < 6; i++)
            emit(K_REPLY, 8'h00, 2'd0, 8'd0, 16'd0, ST_DONE);
        if (rep_code == REP_OK) begin
            hs_phase = PH_OPEN;
            emit(K_STATUS, 8'h00, 2'd0, 8'd0, 16'd0, ST_DONE);
        end else begin
            abort_exchange(ST_UNSUPPORTED);
        end
    endfunction

    function automatic void check_request(input logic [7:0] b);
        if (hdr[0] != SOCKS_VER || hdr[2] != RSV_BYTE) begin
            abort_exchange(ST_BAD_VERSION);
        end else if (!(hdr[1] inside {CMD_CONNECT, CMD_BIND, CMD_UDP})) begin
            abort_exchange(ST_UNKNOWN_CMD);
        end else begin
            rep_code = (hdr[1] == CMD_CONNECT) ? REP_OK : REP_UNSUPPORTED;
            if (hdr[3] == ATYP_DOMAIN) begin
                if (b == 8'h00) begin
                    abort_exchange(ST_ZERO_DOMAIN);
                end else begin
                    dest_kind  = DK_DOMAIN;
                    addr_total = b;
                    addr_left  = b;
                    hs_phase   = PH_ADDRESS;
                end
            end else if (hdr[3] == ATYP_IPV4 || hdr[3] == ATYP_IPV6) begin
                dest_kind  = (hdr[3] == ATYP_IPV4) ? DK_IPV4 : DK_IPV6;
                addr_total = (hdr[3] == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
                addr_left  = addr_total - 8'd1;
                emit(K_ADDR, b, 2'd0, 8'd0, 16'd0, ST_DONE);
                hs_phase   = PH_ADDRESS;
            end else begin
                abort_exchange(ST_UNKNOWN_ATYP);
            end
        end
    endfunction

    function automatic void handshake_step(input t_in_item it);
        logic [7:0] b;
        int         n0;
        t_out_item  r;
        b  = it.rx_byte;
        n0 = server_results.size();
        if (hs_phase == PH_CLOSED)
            return;
        if (it.peer_closed) begin
            if (hs_phase == PH_OPEN)
                hs_phase = PH_CLOSED;
            else
                abort_exchange(ST_PEER_CLOSED);
        end else begin
            case (hs_phase)
                PH_GREETING: begin
                    if (hs_count == 8'd0) begin
                        hdr[0]   = b;
                        hs_count = 8'd1;
                    end else begin
                        hs_count = 8'd0;
                        if (hdr[0] != SOCKS_VER) begin
                            abort_exchange(ST_BAD_VERSION);
                        end else if (b == 8'h00) begin
                            abort_exchange(ST_NO_METHODS);
                        end else begin
                            methods_left = b;
                            no_auth_seen = 1'b0;
                            hs_phase     = PH_METHODS;
                        end
                    end
                end
                PH_METHODS: begin
                    if (b == METHOD_NO_AUTH)
                        no_auth_seen = 1'b1;
                    methods_left = methods_left - 8'd1;
                    if (methods_left == 8'd0) begin
                        emit(K_REPLY, SOCKS_VER, 2'd0, 8'd0, 16'd0, ST_DONE);
                        if (no_auth_seen) begin
                            emit(K_REPLY, METHOD_NO_AUTH, 2'd0, 8'd0, 16'd0, ST_DONE);
                            hs_phase = PH_REQUEST;
                            hs_count = 8'd0;
                        end else begin
                            emit(K_REPLY, METHOD_NONE, 2'd0, 8'd0, 16'd0, ST_DONE);
                            abort_exchange(ST_NO_ACCEPT);
                        end
                    end
                end
                PH_REQUEST: begin
                    if (hs_count < 8'd4) begin
                        hdr[hs_count[1:0]] = b;
                        hs_count = hs_count + 8'd1;
                    end else begin
                        hs_count = 8'd0;
                        check_request(b);
                    end
                end
                PH_ADDRESS: begin
                    emit(K_ADDR, b, 2'd0, 8'd0, 16'd0, ST_DONE);
                    addr_left = addr_left - 8'd1;
                    if (addr_left == 8'd0) begin
                        hs_phase = PH_PORT;
                        hs_count = 8'd0;
                    end
                end
                PH_PORT: begin
                    if (hs_count == 8'd0) begin
                        port_value = {8'h00, b};
                        hs_count   = 8'd1;
                    end else begin
                        hs_count   = 8'd0;
                        port_value = {port_value[7:0], b};
                        send_reply();
                    end
                end
                default: emit(K_PAYLOAD, b, 2'd0, 8'd0, 16'd0, ST_DONE);
            endcase
        end
        if (server_results.size() > n0) begin
            r = server_results.pop_back();
            r.last = 1'b1;
            server_results.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (server_results.size() == 0) begin
            $error("unexpected result: kind %0d data %02h status %0d",
                   got.kind, got.data, got.status);
            error_count++;
            return;
        end
        want = server_results.pop_front();
        results_checked++;
        check_field("kind", want.kind, got.kind);
        check_field("data", want.data, got.data);
        check_field("addr_kind", want.addr_kind, got.addr_kind);
        check_field("address_length", want.address_length, got.address_length);
        check_field("dest_port", want.dest_port, got.dest_port);
        check_field("status", want.status, got.status);
        check_field("last", want.last, got.last);
    endfunction

    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall)
            check_result(o_out_item);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic closed);
        t_in_item it;
        it.rx_byte     = b;
        it.peer_closed = closed;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        handshake_step(it);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (server_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_greeting();
        int         pick;
        int         zero_at;
        logic [7:0] m;
        pick = $urandom_range(3);
        method_count = (pick == 0) ? 1 : (pick == 1) ? 255 : $urandom_range(2, 8);
        zero_at = $urandom_range(method_count - 1);
        send_byte(SOCKS_VER, 1'b0);
        send_byte(8'(method_count), 1'b0);
        for (int i = 0; i < method_count; i++) begin
            m = (i == zero_at) ? METHOD_NO_AUTH : 8'($urandom_range(255));
            send_byte(m, 1'b0);
        end
    endtask

    task automatic test_request();
        int          pick;
        int          alen;
        logic [15:0] port;
        pick = $urandom_range(2);
        req_atyp = (pick == 0) ? ATYP_IPV4 : (pick == 1) ? ATYP_DOMAIN : ATYP_IPV6;
        send_byte(SOCKS_VER, 1'b0);
        send_byte(CMD_CONNECT, 1'b0);
        send_byte(RSV_BYTE, 1'b0);
        send_byte(req_atyp, 1'b0);
        if (req_atyp == ATYP_DOMAIN) begin
            pick = $urandom_range(3);
            // the longest name only when the greeting was short
            alen = (pick == 0) ? 1 : (pick == 1 && method_count <= 8) ? 255
                                   : $urandom_range(2, 40);
            send_byte(8'(alen), 1'b0);
        end else begin
            alen = (req_atyp == ATYP_IPV4) ? IPV4_LEN : IPV6_LEN;
        end
        for (int i = 0; i < alen; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
        pick = $urandom_range(2);
        port = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(65535));
        send_byte(port[15:8], 1'b0);
        send_byte(port[7:0], 1'b0);
    endtask

    task automatic test_payload_edges();
        logic [7:0] edge_bytes [6];
        edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA};
        foreach (edge_bytes[i])
            send_byte(edge_bytes[i], 1'b0);
        // hold the sender back until the output side has caught up
        wait_drained();
    endtask

    task automatic test_payload_random();
        int idle_mix [4][2];
        int per_phase;
        idle_mix = '{'{0, 0}, '{56, 0}, '{0, 56}, '{24, 24}};
        // share what is left of the item budget, keeping room for the close test
        per_phase = (N_ITEMS - 7 - bytes_sent) / 4;
        if (per_phase < 20)
            per_phase = 20;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_mix[p][0];
            recv_stall_pct = idle_mix[p][1];
            for (int i = 0; i < per_phase; i++)
                send_byte(8'($urandom_range(255)), 1'b0);
            wait_drained();
        end
    endtask

    task automatic test_peer_close();
        send_byte(8'($urandom_range(255)), 1'b1);
        // connection is shut, everything after must be ignored
        for (int i = 0; i < 6; i++)
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        test_greeting();
        test_request();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_payload_edges();
        test_payload_random();
        test_peer_close();
        wait_drained();
        repeat (40) @(posedge clk);
        $display("tb: %0d bytes accepted, %0d results checked", bytes_sent, results_checked);
        $display("tb: %0d methods offered, address type %0d, payload under four idle mixes",
                 method_count, req_atyp);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(12 * 300000);
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
design/s5h_pkg.sv
design/s5h_front.sv
design/s5h_fifo.sv
design/s5h_back.sv
design/socks5_server_handshake.sv
tb/testbench.sv
